/* rtl/one_wire_serial_number_slave_unit_defines.svh */
// Assertion macros used by the one-wire serial number slave checker.
`ifndef ONE_WIRE_SERIAL_NUMBER_SLAVE_UNIT_DEFINES_SVH
`define ONE_WIRE_SERIAL_NUMBER_SLAVE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OWSN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("owsn check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define OWSN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("owsn check failed");

`endif

/* rtl/owsn_pkg.sv */
// Types and constants of the one-wire serial number slave.
package owsn_pkg;

  localparam int unsigned ROM_W      = 64;
  localparam int unsigned PIN_W      = 3;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 64;

  localparam int unsigned RESET_LOW_US = 480;
  localparam int unsigned ONE_BIT_US   = 15;
  localparam logic [7:0]  READ_ROM_CMD = 8'h33;
  localparam logic [3:0]  CMD_BITS     = 4'd8;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DIR    = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_t;

  typedef enum logic {
    REG_ROM = 1'b0,
    REG_PIN = 1'b1
  } reg_sel_t;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_PRESENCE = 4'b0010,
    MODE_RECEIVE  = 4'b0100,
    MODE_READ_ROM = 4'b1000
  } mode_t;

  typedef struct packed {
    logic               fire;
    logic               is_dir;
    logic               port_bit;
    logic [STAMP_W-1:0] stamp;
  } pin_event_t;

endpackage

/* rtl/owsn_core.sv */
// Line tracking, command receive and ROM bit sequencing of the slave.
module owsn_core #(
  parameter int unsigned CYCLES_PER_US = 18,
  parameter int unsigned ROM_BITS      = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  owsn_pkg::pin_event_t           ev,
  input  logic [owsn_pkg::ROM_W-1:0]     rom_contents,
  output logic                           slave_pulls_low
);

  localparam logic [owsn_pkg::STAMP_W-1:0] LONG_CYC =
    owsn_pkg::STAMP_W'((owsn_pkg::RESET_LOW_US + 1) * CYCLES_PER_US);
  localparam logic [owsn_pkg::STAMP_W-1:0] SHORT_CYC =
    owsn_pkg::STAMP_W'(owsn_pkg::ONE_BIT_US * CYCLES_PER_US);
  localparam logic [owsn_pkg::POS_W-1:0] POS_LAST = owsn_pkg::POS_W'(ROM_BITS + 1);
  localparam logic [owsn_pkg::POS_W-1:0] POS_TOP  = owsn_pkg::POS_W'(ROM_BITS);

  logic                           line_level_prev, line_level_prev_next;
  logic [owsn_pkg::STAMP_W-1:0]   last_edge_time, last_edge_time_next;
  owsn_pkg::mode_t                slave_mode, slave_mode_next;
  logic [7:0]                     receive_shift, receive_shift_next;
  logic [3:0]                     receive_count, receive_count_next;
  logic [owsn_pkg::POS_W-1:0]     send_position, send_position_next;
  logic                           host_drives, host_drives_next;
  logic                           host_level, host_level_next;

  always_comb begin
    logic                         level;
    logic [owsn_pkg::STAMP_W-1:0] base;
    logic [owsn_pkg::STAMP_W-1:0] diff;
    line_level_prev_next = line_level_prev;
    last_edge_time_next  = last_edge_time;
    slave_mode_next      = slave_mode;
    receive_shift_next   = receive_shift;
    receive_count_next   = receive_count;
    send_position_next   = send_position;
    host_drives_next     = host_drives;
    host_level_next      = host_level;
    level = 1'b0;
    base  = '0;
    diff  = '0;
    if (ev.fire) begin
      if (ev.is_dir) begin
        host_drives_next = ev.port_bit;
      end else begin
        host_level_next = ev.port_bit;
      end
      level = !host_drives_next || host_level_next;
      base  = (last_edge_time == '0) ? ev.stamp : last_edge_time;
      diff  = ev.stamp - base;
      last_edge_time_next = base;
      if (level != line_level_prev) begin
        if (level) begin
          if (diff >= LONG_CYC) begin
            slave_mode_next = owsn_pkg::MODE_PRESENCE;
          end else if (slave_mode == owsn_pkg::MODE_PRESENCE) begin
            slave_mode_next    = owsn_pkg::MODE_RECEIVE;
            receive_shift_next = '0;
            receive_count_next = '0;
          end
          if (slave_mode_next == owsn_pkg::MODE_RECEIVE) begin
            receive_shift_next = {diff < SHORT_CYC, receive_shift_next[7:1]};
            receive_count_next = receive_count_next + 4'd1;
            if (receive_count_next == owsn_pkg::CMD_BITS) begin
              if (receive_shift_next == owsn_pkg::READ_ROM_CMD) begin
                slave_mode_next    = owsn_pkg::MODE_READ_ROM;
                send_position_next = '0;
              end else begin
                slave_mode_next = owsn_pkg::MODE_PRESENCE;
              end
            end
          end else if (slave_mode_next == owsn_pkg::MODE_READ_ROM) begin
            if (send_position < POS_LAST) begin
              send_position_next = send_position + 1'b1;
            end
          end
        end
        last_edge_time_next = ev.stamp;
      end
      line_level_prev_next = level;
    end
  end

  always_comb begin
    logic [5:0] idx;
    idx = 6'(send_position_next - 1'b1);
    if (slave_mode_next == owsn_pkg::MODE_READ_ROM) begin
      slave_pulls_low = (send_position_next != '0) && (send_position_next <= POS_TOP) &&
                        !rom_contents[idx];
    end else begin
      slave_pulls_low = (slave_mode_next == owsn_pkg::MODE_PRESENCE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_level_prev <= 1'b0;
      last_edge_time  <= '0;
      slave_mode      <= owsn_pkg::MODE_IDLE;
      receive_shift   <= '0;
      receive_count   <= '0;
      send_position   <= '0;
      host_drives     <= 1'b0;
      host_level      <= 1'b0;
    end else begin
      line_level_prev <= line_level_prev_next;
      last_edge_time  <= last_edge_time_next;
      slave_mode      <= slave_mode_next;
      receive_shift   <= receive_shift_next;
      receive_count   <= receive_count_next;
      send_position   <= send_position_next;
      host_drives     <= host_drives_next;
      host_level      <= host_level_next;
    end
  end

endmodule

/* rtl/one_wire_serial_number_slave_unit.sv */
// Each transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while out_stall is low; owsn_core steps as each result loads.
// Input register and result register each move on when the stage ahead frees up.
// Reset (rst, synchronous): slave idle, line low, timers cleared, ROM code and
// pin index zero, both pipeline stages empty.
module one_wire_serial_number_slave_unit #(
  parameter int unsigned CYCLES_PER_US = 18,
  parameter int unsigned ROM_BITS      = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [7:0]                      port_byte,
  input  logic [owsn_pkg::STAMP_W-1:0]    time_stamp,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      read_byte,
  output logic                            slave_pulls_low,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [owsn_pkg::ADDR_W-1:0]     paddr,
  input  logic [owsn_pkg::DATA_W-1:0]     pwdata,
  output logic [owsn_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [owsn_pkg::ROM_W-1:0]   rom_contents;
  logic [owsn_pkg::PIN_W-1:0]   pin_index;
  logic                         s1_valid;
  logic [1:0]                   s1_opcode;
  logic [7:0]                   s1_port_byte;
  logic [owsn_pkg::STAMP_W-1:0] s1_time_stamp;
  logic                         in_accept;
  logic                         out_load;
  logic                         core_low;
  logic                         cfg_write;
  owsn_pkg::reg_sel_t           reg_sel;
  owsn_pkg::pin_event_t         ev;

  assign pready    = 1'b1;
  assign reg_sel   = owsn_pkg::reg_sel_t'(paddr[3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      owsn_pkg::REG_ROM: prdata = rom_contents;
      owsn_pkg::REG_PIN: prdata = owsn_pkg::DATA_W'(pin_index);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_contents <= '0;
      pin_index    <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        owsn_pkg::REG_ROM: rom_contents <= pwdata;
        owsn_pkg::REG_PIN: pin_index    <= pwdata[owsn_pkg::PIN_W-1:0];
        default:           rom_contents <= rom_contents;
      endcase
    end
  end

  assign out_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode     <= opcode;
      s1_port_byte  <= port_byte;
      s1_time_stamp <= time_stamp;
    end
  end

  assign ev.fire     = out_load && ((s1_opcode == owsn_pkg::OP_WRITE) ||
                                    (s1_opcode == owsn_pkg::OP_DIR));
  assign ev.is_dir   = (s1_opcode == owsn_pkg::OP_DIR);
  assign ev.port_bit = s1_port_byte[pin_index];
  assign ev.stamp    = s1_time_stamp;

  owsn_core #(
    .CYCLES_PER_US (CYCLES_PER_US),
    .ROM_BITS      (ROM_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .ev              (ev),
    .rom_contents    (rom_contents),
    .slave_pulls_low (core_low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slave_pulls_low <= core_low;
      read_byte       <= core_low ? 8'h00 : (8'h01 << pin_index);
    end
  end

endmodule

/* rtl/owsn_checker.sv */
// Port-level checks of the one-wire serial number slave, bound to the top level.
`include "one_wire_serial_number_slave_unit_defines.svh"

module owsn_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_byte,
  input logic       slave_pulls_low
);

  `OWSN_ASSERT_NOW(a_low_reads_zero, out_valid && slave_pulls_low, read_byte == 8'h00)
  `OWSN_ASSERT_NOW(a_high_one_bit, out_valid && !slave_pulls_low, $countones(read_byte) == 1)
  `OWSN_ASSERT_NOW(a_empty_after_reset, $past(rst), !out_valid)
  `OWSN_ASSERT_NEXT(a_stall_holds_byte, out_valid && out_stall, out_valid && $stable(read_byte))
  `OWSN_ASSERT_NEXT(a_stall_holds_flag, out_valid && out_stall, $stable(slave_pulls_low))

endmodule

bind one_wire_serial_number_slave_unit owsn_checker u_owsn_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .read_byte       (read_byte),
  .slave_pulls_low (slave_pulls_low)
);

/* tb/one_wire_serial_number_slave_unit_tb.sv */
// Self-checking testbench for the one-wire serial number slave: host pin events in, line view out.
`timescale 1ns / 1ps

module one_wire_serial_number_slave_unit_tb;

  localparam int unsigned CYCLES_PER_US = 18;
  localparam int unsigned ROM_BITS      = 64;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  localparam int unsigned ONE_MAX_CYC   = owsn_pkg::ONE_BIT_US * CYCLES_PER_US - 1;
  localparam int unsigned RESET_MIN_CYC = (owsn_pkg::RESET_LOW_US + 1) * CYCLES_PER_US;
  localparam int unsigned ZERO_MAX_CYC  = RESET_MIN_CYC - 1;

  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_EVENTS  = 135;
  localparam int unsigned DRAIN_PAD     = 4;
  localparam int unsigned WATCHDOG_CYC  = 2000;

  typedef struct {
    logic [1:0]                   op;
    logic [7:0]                   port_byte;
    logic [owsn_pkg::STAMP_W-1:0] stamp;
  } host_event_t;

  typedef struct {
    logic [7:0] read_byte;
    logic       pulls_low;
  } line_view_t;

  logic                          clk             = 1'b0;
  logic                          rst             = 1'b1;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic [1:0]                    opcode          = '0;
  logic [7:0]                    port_byte       = '0;
  logic [owsn_pkg::STAMP_W-1:0]  time_stamp      = '0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [7:0]                    read_byte;
  logic                          slave_pulls_low;
  logic                          psel            = 1'b0;
  logic                          penable         = 1'b0;
  logic                          pwrite          = 1'b0;
  logic [owsn_pkg::ADDR_W-1:0]   paddr           = '0;
  logic [owsn_pkg::DATA_W-1:0]   pwdata          = '0;
  logic [owsn_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  one_wire_serial_number_slave_unit #(
    .CYCLES_PER_US(CYCLES_PER_US),
    .ROM_BITS     (ROM_BITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .port_byte      (port_byte),
    .time_stamp     (time_stamp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .slave_pulls_low(slave_pulls_low),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Slave state as the host sees it, plus the register copies.
  logic [owsn_pkg::ROM_W-1:0]   rom_code   = '0;
  logic [owsn_pkg::PIN_W-1:0]   pin_sel    = '0;
  logic                         line_prev  = 1'b0;
  logic [owsn_pkg::STAMP_W-1:0] last_edge  = '0;
  owsn_pkg::mode_t              mode       = owsn_pkg::MODE_IDLE;
  logic [7:0]                   rx_shift   = '0;
  logic [3:0]                   rx_count   = '0;
  logic [owsn_pkg::POS_W-1:0]   rom_pos    = '0;
  logic                         host_dir   = 1'b0;
  logic                         host_out   = 1'b0;

  host_event_t                  host_events[$];
  line_view_t                   pending_views[$];
  logic [owsn_pkg::STAMP_W-1:0] stamp_now      = '0;
  logic                         drive_by_dir   = 1'b1;
  logic                         calm           = 1'b0;
  logic                         in_taken       = 1'b0;
  int unsigned                  in_gap         = 0;
  int unsigned                  hold_left      = 0;
  int unsigned                  events_queued  = 0;
  int unsigned                  events_taken   = 0;
  int unsigned                  views_checked  = 0;
  int unsigned                  idle_cycles    = 0;
  int unsigned                  err_count      = 0;
  int unsigned                  settings_used  = 0;
  int unsigned                  reset_pulses   = 0;
  int unsigned                  rom_entries    = 0;
  int unsigned                  rom_bits_sent  = 0;

  function automatic void predict_line_view(input logic [1:0] op, input logic [7:0] pb,
                                            input logic [owsn_pkg::STAMP_W-1:0] stamp);
    logic                         level;
    logic                         low;
    logic [owsn_pkg::STAMP_W-1:0] span;
    logic [owsn_pkg::STAMP_W-1:0] low_us;
    line_view_t                   v;
    if (op == owsn_pkg::OP_WRITE) begin
      host_out = pb[pin_sel];
    end else if (op == owsn_pkg::OP_DIR) begin
      host_dir = pb[pin_sel];
    end
    if (op == owsn_pkg::OP_WRITE || op == owsn_pkg::OP_DIR) begin
      level = !host_dir || host_out;
      if (last_edge == '0) begin
        last_edge = stamp;
      end
      if (level != line_prev) begin
        span   = stamp - last_edge;
        low_us = span / CYCLES_PER_US;
        if (level) begin
          if (low_us > owsn_pkg::RESET_LOW_US) begin
            mode = owsn_pkg::MODE_PRESENCE;
            reset_pulses++;
          end else if (mode == owsn_pkg::MODE_PRESENCE) begin
            mode     = owsn_pkg::MODE_RECEIVE;
            rx_shift = '0;
            rx_count = '0;
          end
          if (mode == owsn_pkg::MODE_RECEIVE) begin
            rx_shift = {low_us < owsn_pkg::ONE_BIT_US, rx_shift[7:1]};
            rx_count = rx_count + 4'd1;
            if (rx_count == owsn_pkg::CMD_BITS) begin
              mode = owsn_pkg::MODE_PRESENCE;
              if (rx_shift == owsn_pkg::READ_ROM_CMD) begin
                mode    = owsn_pkg::MODE_READ_ROM;
                rom_pos = '0;
                rom_entries++;
              end
            end
          end else if (mode == owsn_pkg::MODE_READ_ROM && rom_pos < ROM_BITS + 1) begin
            rom_pos = rom_pos + 7'd1;
            if (rom_pos <= ROM_BITS) begin
              rom_bits_sent++;
            end
          end
        end
        last_edge = stamp;
      end
      line_prev = level;
    end
    if (mode == owsn_pkg::MODE_READ_ROM) begin
      low = rom_pos != '0 && rom_pos <= ROM_BITS && !rom_code[6'(rom_pos - 7'd1)];
    end else begin
      low = mode == owsn_pkg::MODE_PRESENCE;
    end
    v.read_byte = low ? 8'h00 : (8'h01 << pin_sel);
    v.pulls_low = low;
    pending_views.push_back(v);
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pin_byte(input logic level);
    logic [7:0] b;
    b = 8'($urandom);
    b[pin_sel] = level;
    return b;
  endfunction

  function automatic int unsigned one_low();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return ONE_MAX_CYC;
    end
    if (r == 1) begin
      return 0;
    end
    return $urandom_range(1, ONE_MAX_CYC - 1);
  endfunction

  function automatic int unsigned zero_low();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return ONE_MAX_CYC + 1;
    end
    if (r == 1) begin
      return ZERO_MAX_CYC;
    end
    return $urandom_range(ONE_MAX_CYC + 2, 1500);
  endfunction

  function automatic int unsigned reset_low();
    if ($urandom_range(0, 4) == 0) begin
      return RESET_MIN_CYC;
    end
    return $urandom_range(RESET_MIN_CYC, 1000 * CYCLES_PER_US);
  endfunction

  task automatic add_event(input logic [1:0] op, input logic [7:0] pb);
    host_events.push_back('{op: op, port_byte: pb, stamp: stamp_now});
    events_queued++;
  endtask

  task automatic maybe_sample();
    if ($urandom_range(0, 3) == 0) begin
      add_event($urandom_range(0, 1) ? owsn_pkg::OP_SAMPLE : OP_UNUSED, 8'($urandom));
    end
  endtask

  task automatic set_line(input logic high);
    if (drive_by_dir) begin
      add_event(owsn_pkg::OP_DIR, pin_byte(!high));
    end else begin
      add_event(owsn_pkg::OP_WRITE, pin_byte(high));
    end
  endtask

  // Either toggle direction with the output held low, or toggle the output while driving.
  task automatic pick_drive();
    drive_by_dir = 1'($urandom_range(0, 1));
    add_event(owsn_pkg::OP_WRITE, pin_byte(!drive_by_dir));
    stamp_now += $urandom_range(1, 50);
    add_event(owsn_pkg::OP_DIR, pin_byte(!drive_by_dir));
    stamp_now += $urandom_range(1, 50);
  endtask

  task automatic line_slot(input int unsigned low_cycles);
    set_line(1'b0);
    maybe_sample();
    stamp_now += low_cycles;
    set_line(1'b1);
    stamp_now += ($urandom_range(0, 9) == 0) ? $urandom_range(200, 20000)
                                             : $urandom_range(1, 150);
    maybe_sample();
  endtask

  task automatic send_command(input logic [7:0] cmd);
    for (int i = 0; i < 8; i++) begin
      line_slot(cmd[i] ? one_low() : zero_low());
    end
  endtask

  task automatic write_reg(input owsn_pkg::reg_sel_t sel,
                           input logic [owsn_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= owsn_pkg::ADDR_W'(8 * int'(sel));
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == owsn_pkg::REG_ROM) begin
      rom_code = value;
    end else begin
      pin_sel = value[owsn_pkg::PIN_W-1:0];
    end
  endtask

  task automatic wait_drained();
    while (events_taken != events_queued || pending_views.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  always @(negedge clk) begin : host_driver
    host_event_t ev;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (host_events.size() != 0) begin
        ev = host_events.pop_front();
        opcode     <= ev.op;
        port_byte  <= ev.port_byte;
        time_stamp <= ev.stamp;
        in_valid   <= 1'b1;
        in_gap     <= idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_stall
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= 1'b0;
      hold_left <= idle_len();
    end
  end

  always @(posedge clk) begin : line_monitor
    line_view_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_line_view(opcode, port_byte, time_stamp);
        events_taken++;
      end
      if (out_valid && !out_stall) begin
        if (pending_views.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result read_byte=%02h slave_pulls_low=%0b",
                   $time, read_byte, slave_pulls_low);
        end else begin
          want = pending_views.pop_front();
          views_checked++;
          if (read_byte !== want.read_byte) begin
            err_count++;
            $display("%0t: read_byte expected %02h actual %02h",
                     $time, want.read_byte, read_byte);
          end
          if (slave_pulls_low !== want.pulls_low) begin
            err_count++;
            $display("%0t: slave_pulls_low expected %0b actual %0b",
                     $time, want.pulls_low, slave_pulls_low);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_CYC) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("FAIL one_wire_serial_number_slave_unit");
        $finish;
      end
    end
  end

  initial begin : test_sequence
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    logic [63:0] rom_value;
    logic [7:0]  cmd;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(owsn_pkg::REG_ROM, {$urandom, $urandom});
    write_reg(owsn_pkg::REG_PIN, '0);
    settings_used = 1;

    // Directed: all opcodes, zero and top stamps, reset and bit-width boundaries.
    stamp_now = '0;
    add_event(owsn_pkg::OP_SAMPLE, 8'hFF);
    add_event(OP_UNUSED, 8'h00);
    add_event(owsn_pkg::OP_WRITE, 8'h00);
    stamp_now = 100;
    add_event(owsn_pkg::OP_DIR, 8'hFF);
    stamp_now = 300;
    add_event(owsn_pkg::OP_DIR, 8'h00);
    stamp_now = 1000;
    add_event(owsn_pkg::OP_DIR, 8'hFF);
    stamp_now += ZERO_MAX_CYC;
    add_event(owsn_pkg::OP_DIR, 8'h00);
    stamp_now += 50;
    add_event(owsn_pkg::OP_DIR, 8'hFF);
    stamp_now += RESET_MIN_CYC;
    add_event(owsn_pkg::OP_DIR, 8'h00);
    add_event(owsn_pkg::OP_SAMPLE, 8'h00);
    stamp_now += 40;
    add_event(owsn_pkg::OP_DIR, 8'hFF);
    stamp_now += ONE_MAX_CYC;
    add_event(owsn_pkg::OP_DIR, 8'h00);
    stamp_now = '1;
    add_event(owsn_pkg::OP_DIR, 8'hFF);
    stamp_now += ONE_MAX_CYC + 1;
    add_event(owsn_pkg::OP_DIR, 8'h00);
    add_event(OP_UNUSED, 8'hFF);
    add_event(owsn_pkg::OP_WRITE, 8'hFF);
    add_event(owsn_pkg::OP_DIR, 8'hFF);
    stamp_now += 20;
    add_event(owsn_pkg::OP_WRITE, 8'h00);
    stamp_now += 10;
    add_event(owsn_pkg::OP_WRITE, 8'hFF);
    add_event(owsn_pkg::OP_SAMPLE, 8'hFF);
    wait_drained();

    for (int unsigned phase = 1; phase <= PHASES; phase++) begin
      calm = (phase % 3 == 0);
      if (phase == 1) begin
        rom_value = '0;
      end else if (phase == 2) begin
        rom_value = '1;
      end else if (phase == 3) begin
        rom_value = {1'b1, 62'd0, 1'b1};
      end else begin
        rom_value = {$urandom, $urandom};
      end
      write_reg(owsn_pkg::REG_ROM, rom_value);
      write_reg(owsn_pkg::REG_PIN, owsn_pkg::DATA_W'(phase % 8));
      settings_used++;
      stamp_now = $urandom;
      stop_at = events_queued + PHASE_EVENTS;
      while (events_queued < stop_at) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          pick_drive();
          line_slot(reset_low());
          cmd = ($urandom_range(0, 4) != 0) ? owsn_pkg::READ_ROM_CMD : 8'($urandom);
          send_command(cmd);
          n = ($urandom_range(0, 9) < 7) ? $urandom_range(ROM_BITS, ROM_BITS + 6)
                                         : $urandom_range(0, ROM_BITS - 1);
          repeat (n) line_slot($urandom_range(0, 600));
        end else if (pick < 8) begin
          // Cut a command or a read short with another reset pulse.
          pick_drive();
          line_slot(reset_low());
          n = $urandom_range(0, 7);
          repeat (n) line_slot($urandom_range(0, 1) ? one_low() : zero_low());
          if ($urandom_range(0, 1) != 0) begin
            line_slot(reset_low());
            send_command(owsn_pkg::READ_ROM_CMD);
            repeat ($urandom_range(1, 10)) line_slot(one_low());
            line_slot(reset_low());
          end
        end else begin
          n = $urandom_range(4, 16);
          repeat (n) begin
            add_event(2'($urandom_range(0, 3)), 8'($urandom));
            if ($urandom_range(0, 15) == 0) begin
              stamp_now = $urandom;
            end else begin
              stamp_now += $urandom_range(0, 20000);
            end
          end
        end
      end
      wait_drained();
    end

    $display("%0d transactions checked across %0d register settings",
             views_checked, settings_used);
    $display("%0d reset pulses, %0d read-ROM commands, %0d ROM bits presented",
             reset_pulses, rom_entries, rom_bits_sent);
    if (err_count == 0) begin
      $display("PASS one_wire_serial_number_slave_unit");
    end else begin
      $display("FAIL one_wire_serial_number_slave_unit");
    end
    $finish;
  end

endmodule
